@@ design/overdrive_sample_chain_top_defines.svh @@
// Assertion macros used by the overdrive chain checker.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef OVERDRIVE_SAMPLE_CHAIN_TOP_DEFINES_SVH
`define OVERDRIVE_SAMPLE_CHAIN_TOP_DEFINES_SVH

// antecedent holds -> consequent holds in the same cycle
`define OSC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("osc assertion failed");

// antecedent holds -> consequent holds in the next cycle
`define OSC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("osc assertion failed");

`endif

@@ design/osc_pkg.sv @@
// Types, constants and small helpers of the overdrive sample chain.
// No dependencies; used by the top level and the checker.
package osc_pkg;

    localparam int CFG_W = 16;
    localparam int IDX_W = 3;

    localparam logic [IDX_W-1:0] REG_DRIVE  = 3'd0;
    localparam logic [IDX_W-1:0] REG_BASS   = 3'd1;
    localparam logic [IDX_W-1:0] REG_TREBLE = 3'd2;
    localparam logic [IDX_W-1:0] REG_VOLUME = 3'd3;
    localparam logic [IDX_W-1:0] REG_POLE   = 3'd4;

    localparam int BLOCK_R   = 32604;
    localparam int TREB_R    = 31785;
    localparam int CLIP_POS  = 85197;
    localparam int CLIP_NEG  = 76677;
    localparam int VOL_SCALE = 58982;
    localparam int LIM_SCALE = 31130;
    localparam int LIM_MAX   = 393216;
    localparam int ONE_Q17   = 131072;
    localparam int LIM_K     = 27 * ONE_Q17;

    // quotient bits of the shared divider, and its counter width
    localparam int DIV_BITS  = 20;
    localparam int DIV_CNT_W = 5;

    typedef struct packed {
        logic signed [15:0] sample_in;
        logic               channel;
    } in_beat_t;

    typedef struct packed {
        logic signed [15:0] sample_out;
        logic               out_channel;
    } out_beat_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_LOAD,
        ST_M_IB, ST_A_IB, ST_M_LP, ST_A_LP, ST_M_BT, ST_A_BT,
        ST_M_DR, ST_A_DR, ST_DIV, ST_CLIP,
        ST_M_TR, ST_A_TR, ST_M_TG, ST_A_TG,
        ST_M_B1, ST_M_B2, ST_A_BL, ST_M_V1, ST_M_V2, ST_A_V,
        ST_M_OB, ST_A_OB, ST_M_LU, ST_A_LU, ST_M_U2, ST_A_U2,
        ST_M_LN, ST_A_LN, ST_FIN
    } state_t;

    // knob values above 1.0 act as 1.0
    function automatic logic [16:0] knob(input logic [15:0] v);
        knob = (v > 16'd32768) ? 17'd32768 : {1'b0, v};
    endfunction

endpackage

@@ design/overdrive_sample_chain_top.sv @@
// Overdrive sample chain, top level: sequencer, shared multiplier and divider.
// Depends on osc_pkg and osc_ram.
//
// Usage:
//   in channel (in_valid / in_stall / in_data): one sample and its channel
//   index per beat. out channel (out_valid / out_stall / out_data): one
//   processed sample per input beat, channel echoed, in input order.
//   Configuration: cfg_write with cfg_index / cfg_data, one register a cycle,
//   only while the block is idle.
// Timing:
//   One sample at a time. A beat passes the sequencer steps from acceptance to
//   the output register, with an extra divider pass when the clipper's knee
//   is hit; the shared restoring divider yields one quotient bit a cycle, and
//   every multiply step goes through the shared multiplier register.
//   The next beat is taken in the cycle after the result is loaded.
//   The per-channel filter states sit in one RAM word per channel, read at
//   acceptance and written back at the end.
// Reset: all states read as zero (one valid bit per channel), knobs return
//   to their defaults, no result pending.
// Stall: a result waits in the output register; the sequencer holds in its
//   last step until the register is free, and in_stall stays high meanwhile.
module overdrive_sample_chain_top #(
    parameter int NUM_CHANNELS   = 2,
    parameter int INTERNAL_WIDTH = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  osc_pkg::in_beat_t               in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output osc_pkg::out_beat_t              out_data,
    input  logic                            cfg_write,
    input  logic [osc_pkg::IDX_W-1:0]       cfg_index,
    input  logic [osc_pkg::CFG_W-1:0]       cfg_data
);

    localparam int XW  = INTERNAL_WIDTH;
    localparam int XW1 = INTERNAL_WIDTH + 1;
    localparam int AW  = NUM_CHANNELS > 1 ? $clog2(NUM_CHANNELS) : 1;
    localparam int WW  = 7 * INTERNAL_WIDTH;

    function automatic logic signed [XW-1:0] sat_w(input logic signed [69:0] v);
        if (v[69:XW-1] == {(71-XW){1'b0}} || v[69:XW-1] == {(71-XW){1'b1}})
        begin
            sat_w = v[XW-1:0];
        end
        else if (v[69])
        begin
            sat_w = {1'b1, {(XW-1){1'b0}}};
        end
        else
        begin
            sat_w = {1'b0, {(XW-1){1'b1}}};
        end
    endfunction

    // round half up, floor shift
    function automatic logic signed [69:0] rnd_sh(input logic signed [69:0] v, input int n);
        rnd_sh = (v + (70'sd1 <<< (n - 1))) >>> n;
    endfunction

    osc_pkg::state_t state_reg, state_next;

    logic [15:0] cfg_drive_reg, cfg_bass_reg, cfg_treble_reg, cfg_volume_reg, cfg_pole_reg;

    logic signed [XW-1:0] clean_reg, x_reg;
    logic signed [XW-1:0] ibi_reg, ibo_reg, lp_reg, tpi_reg, tpo_reg, obi_reg, obo_reg;
    logic [20:0]          u2_reg;
    logic signed [67:0]   p_reg, acc_reg;
    logic [63:0]          rem_reg, dsh_reg;
    logic [osc_pkg::DIV_BITS-1:0]  q_reg;
    logic [osc_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                 div_lim_reg, sign_reg;
    logic                 ch_reg, ld_valid_reg;
    logic [AW-1:0]        addr_reg;
    logic [NUM_CHANNELS-1:0] valid_reg;
    logic                 out_valid_reg;
    osc_pkg::out_beat_t   out_data_reg;

    logic signed [33:0]   mul_a, mul_b;
    logic                 ram_we, in_fire, out_fire;
    logic [AW-1:0]        rd_addr;
    logic [WW-1:0]        ram_rdata, ram_wdata, ld_word;

    logic [16:0]          drive_k, bass_k, treb_k, vol_k, coef_k;
    logic [20:0]          drive_gain;
    logic signed [17:0]   bass_f;
    logic signed [19:0]   treb_d, treb_f;
    logic [16:0]          blend_c, blend_x;

    logic signed [69:0]   p70, r15, r16, r17, r30, rbl, u_c, d70, cl_v, y70;
    logic signed [XW-1:0] dr_x, ib_x, tr_hp, ob_hp;
    logic signed [XW1-1:0] x_m_lp, lp_m_x;
    logic                 clip_p, clip_n;
    logic [63:0]          lim_mag;
    logic [23:0]          lim_den;
    logic [32:0]          clip_den;
    logic signed [21:0]   yq;
    logic signed [15:0]   y16;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_drive_reg  <= 16'd16384;
            cfg_bass_reg   <= 16'd16384;
            cfg_treble_reg <= 16'd16384;
            cfg_volume_reg <= 16'd16384;
            cfg_pole_reg   <= 16'd427;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                osc_pkg::REG_DRIVE:  cfg_drive_reg  <= cfg_data;
                osc_pkg::REG_BASS:   cfg_bass_reg   <= cfg_data;
                osc_pkg::REG_TREBLE: cfg_treble_reg <= cfg_data;
                osc_pkg::REG_VOLUME: cfg_volume_reg <= cfg_data;
                osc_pkg::REG_POLE:   cfg_pole_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign drive_k    = osc_pkg::knob(cfg_drive_reg);
    assign bass_k     = osc_pkg::knob(cfg_bass_reg);
    assign treb_k     = osc_pkg::knob(cfg_treble_reg);
    assign vol_k      = osc_pkg::knob(cfg_volume_reg);
    assign coef_k     = osc_pkg::knob(cfg_pole_reg);
    assign drive_gain = 21'd32768 + 21'(drive_k) * 21'd35;
    assign bass_f     = $signed({bass_k, 1'b0}) - 18'sd32768;
    assign treb_d     = $signed({3'b000, treb_k}) - 20'sd16384;
    assign treb_f     = treb_d * 20'sd5;
    assign blend_c    = 17'd65536 - drive_k;
    assign blend_x    = 17'd32768 + drive_k;

    // ---------------- state RAM ----------------
    assign rd_addr   = (32'(in_data.channel) < NUM_CHANNELS) ? AW'(in_data.channel) : '0;
    assign ram_wdata = {ibi_reg, ibo_reg, lp_reg, tpi_reg, tpo_reg, obi_reg, obo_reg};
    assign ld_word   = ld_valid_reg ? ram_rdata : '0;

    osc_ram #(.WIDTH(WW), .DEPTH(NUM_CHANNELS)) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // ---------------- arithmetic helpers ----------------
    assign p70    = 70'(p_reg);
    assign r15    = rnd_sh(p70, 15);
    assign r16    = rnd_sh(p70, 16);
    assign r17    = rnd_sh(p70, 17);
    assign r30    = rnd_sh(p70, 30);
    assign rbl    = rnd_sh(70'(acc_reg) + p70, 16);
    assign ib_x   = sat_w(70'(clean_reg) - 70'(ibi_reg) + r15);
    assign tr_hp  = sat_w(70'(x_reg) - 70'(tpi_reg) + r15);
    assign ob_hp  = sat_w(70'(x_reg) - 70'(obi_reg) + r15);
    assign x_m_lp = XW1'(x_reg) - XW1'(lp_reg);
    assign lp_m_x = XW1'(lp_reg) - XW1'(x_reg);
    assign dr_x   = sat_w(r15);
    assign clip_p = dr_x > osc_pkg::CLIP_POS;
    assign clip_n = dr_x < -osc_pkg::CLIP_NEG;
    assign d70    = clip_n ? -70'(dr_x) - 70'sd76677 : 70'(dr_x) - 70'sd85197;
    assign clip_den = 33'(d70) + 33'(osc_pkg::ONE_Q17);
    assign lim_mag  = p_reg[67] ? 64'(-p_reg) : 64'(p_reg);
    assign lim_den  = 24'(osc_pkg::LIM_K) + {u2_reg, 3'b000} + 24'(u2_reg);
    assign cl_v   = sign_reg ? -(70'sd76677 + $signed({50'b0, q_reg}))
                             : 70'sd85197 + $signed({50'b0, q_reg});
    assign u_c    = (r15 > 70'sd393216) ? 70'sd393216 :
                    (r15 < -70'sd393216) ? -70'sd393216 : r15;
    assign yq     = sign_reg ? -$signed({2'b00, q_reg}) : $signed({2'b00, q_reg});
    assign y70    = rnd_sh(70'(yq), 2);
    assign y16    = (y70 > 70'sd32767) ? 16'sh7fff :
                    (y70 < -70'sd32768) ? 16'sh8000 : y70[15:0];

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            osc_pkg::ST_IDLE: if (in_valid) state_next = osc_pkg::ST_LOAD;
            osc_pkg::ST_LOAD: state_next = osc_pkg::ST_M_IB;
            osc_pkg::ST_M_IB: state_next = osc_pkg::ST_A_IB;
            osc_pkg::ST_A_IB: state_next = osc_pkg::ST_M_LP;
            osc_pkg::ST_M_LP: state_next = osc_pkg::ST_A_LP;
            osc_pkg::ST_A_LP: state_next = osc_pkg::ST_M_BT;
            osc_pkg::ST_M_BT: state_next = osc_pkg::ST_A_BT;
            osc_pkg::ST_A_BT: state_next = osc_pkg::ST_M_DR;
            osc_pkg::ST_M_DR: state_next = osc_pkg::ST_A_DR;
            osc_pkg::ST_A_DR: state_next = (clip_p || clip_n) ? osc_pkg::ST_DIV
                                                              : osc_pkg::ST_M_TR;
            osc_pkg::ST_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = div_lim_reg ? osc_pkg::ST_FIN : osc_pkg::ST_CLIP;
                end
            end
            osc_pkg::ST_CLIP: state_next = osc_pkg::ST_M_TR;
            osc_pkg::ST_M_TR: state_next = osc_pkg::ST_A_TR;
            osc_pkg::ST_A_TR: state_next = osc_pkg::ST_M_TG;
            osc_pkg::ST_M_TG: state_next = osc_pkg::ST_A_TG;
            osc_pkg::ST_A_TG: state_next = osc_pkg::ST_M_B1;
            osc_pkg::ST_M_B1: state_next = osc_pkg::ST_M_B2;
            osc_pkg::ST_M_B2: state_next = osc_pkg::ST_A_BL;
            osc_pkg::ST_A_BL: state_next = osc_pkg::ST_M_V1;
            osc_pkg::ST_M_V1: state_next = osc_pkg::ST_M_V2;
            osc_pkg::ST_M_V2: state_next = osc_pkg::ST_A_V;
            osc_pkg::ST_A_V:  state_next = osc_pkg::ST_M_OB;
            osc_pkg::ST_M_OB: state_next = osc_pkg::ST_A_OB;
            osc_pkg::ST_A_OB: state_next = osc_pkg::ST_M_LU;
            osc_pkg::ST_M_LU: state_next = osc_pkg::ST_A_LU;
            osc_pkg::ST_A_LU: state_next = osc_pkg::ST_M_U2;
            osc_pkg::ST_M_U2: state_next = osc_pkg::ST_A_U2;
            osc_pkg::ST_A_U2: state_next = osc_pkg::ST_M_LN;
            osc_pkg::ST_M_LN: state_next = osc_pkg::ST_A_LN;
            osc_pkg::ST_A_LN: state_next = osc_pkg::ST_DIV;
            osc_pkg::ST_FIN:  if (out_fire) state_next = osc_pkg::ST_IDLE;
            default:          state_next = osc_pkg::ST_IDLE;
        endcase
    end

    // ---------------- control outputs and multiplier operands ----------------
    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        ram_we = 1'b0;
        case (state_reg)
            osc_pkg::ST_M_IB: begin mul_a = 34'(ibo_reg); mul_b = 34'(osc_pkg::BLOCK_R); end
            osc_pkg::ST_M_LP: begin mul_a = $signed({17'b0, coef_k}); mul_b = 34'(x_m_lp); end
            osc_pkg::ST_M_BT: begin mul_a = 34'(lp_m_x); mul_b = 34'(bass_f); end
            osc_pkg::ST_M_DR: begin mul_a = 34'(x_reg); mul_b = $signed({13'b0, drive_gain}); end
            osc_pkg::ST_M_TR: begin mul_a = 34'(tpo_reg); mul_b = 34'(osc_pkg::TREB_R); end
            osc_pkg::ST_M_TG: begin mul_a = 34'(tpo_reg); mul_b = 34'(treb_f); end
            osc_pkg::ST_M_B1: begin mul_a = 34'(clean_reg); mul_b = $signed({17'b0, blend_c}); end
            osc_pkg::ST_M_B2: begin mul_a = 34'(x_reg); mul_b = $signed({17'b0, blend_x}); end
            osc_pkg::ST_M_V1: begin mul_a = $signed({17'b0, vol_k});
                                    mul_b = 34'(osc_pkg::VOL_SCALE); end
            osc_pkg::ST_M_V2: begin mul_a = 34'(x_reg); mul_b = $signed({2'b00, p_reg[31:0]}); end
            osc_pkg::ST_M_OB: begin mul_a = 34'(obo_reg); mul_b = 34'(osc_pkg::BLOCK_R); end
            osc_pkg::ST_M_LU: begin mul_a = 34'(obo_reg); mul_b = 34'(osc_pkg::LIM_SCALE); end
            osc_pkg::ST_M_U2: begin mul_a = 34'(x_reg); mul_b = 34'(x_reg); end
            osc_pkg::ST_M_LN: begin mul_a = 34'(x_reg);
                                    mul_b = $signed({11'b0, 23'(osc_pkg::LIM_K) + 23'(u2_reg)}); end
            osc_pkg::ST_FIN:  ram_we = 1'b1;
            default: ;
        endcase
    end

    assign in_stall  = (state_reg != osc_pkg::ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_fire  = (state_reg == osc_pkg::ST_FIN) && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= osc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (ram_we)
            begin
                valid_reg[addr_reg] <= 1'b1;
            end
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge clk)
    begin
        p_reg <= mul_a * mul_b;
        if (in_fire)
        begin
            clean_reg    <= XW'(in_data.sample_in) <<< 2;
            ch_reg       <= in_data.channel;
            addr_reg     <= rd_addr;
            ld_valid_reg <= valid_reg[rd_addr];
        end
        if (out_fire)
        begin
            out_data_reg.sample_out  <= y16;
            out_data_reg.out_channel <= ch_reg;
        end
        case (state_reg)
            osc_pkg::ST_LOAD:
            begin
                {ibi_reg, ibo_reg, lp_reg, tpi_reg, tpo_reg, obi_reg, obo_reg} <= ld_word;
            end
            osc_pkg::ST_A_IB:
            begin
                x_reg   <= ib_x;
                ibi_reg <= clean_reg;
                ibo_reg <= ib_x;
            end
            osc_pkg::ST_A_LP: lp_reg <= sat_w(70'(lp_reg) + r15);
            osc_pkg::ST_A_BT: x_reg  <= sat_w(70'(x_reg) + r15);
            osc_pkg::ST_A_DR:
            begin
                x_reg       <= dr_x;
                rem_reg     <= 64'(d70) << 17;
                dsh_reg     <= 64'(clip_den) << (osc_pkg::DIV_BITS - 1);
                sign_reg    <= clip_n;
                div_lim_reg <= 1'b0;
                cnt_reg     <= osc_pkg::DIV_CNT_W'(osc_pkg::DIV_BITS - 1);
                q_reg       <= '0;
            end
            osc_pkg::ST_DIV:
            begin
                if (rem_reg >= dsh_reg)
                begin
                    rem_reg <= rem_reg - dsh_reg;
                    q_reg   <= {q_reg[osc_pkg::DIV_BITS-2:0], 1'b1};
                end
                else
                begin
                    q_reg <= {q_reg[osc_pkg::DIV_BITS-2:0], 1'b0};
                end
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= cnt_reg - 1'b1;
            end
            osc_pkg::ST_CLIP: x_reg <= sat_w(cl_v);
            osc_pkg::ST_A_TR:
            begin
                tpi_reg <= x_reg;
                tpo_reg <= tr_hp;
            end
            osc_pkg::ST_A_TG: x_reg   <= sat_w(70'(x_reg) + r16);
            osc_pkg::ST_M_B2: acc_reg <= p_reg;
            osc_pkg::ST_A_BL: x_reg   <= sat_w(rbl);
            osc_pkg::ST_A_V:  x_reg   <= sat_w(r30);
            osc_pkg::ST_A_OB:
            begin
                obi_reg <= x_reg;
                obo_reg <= ob_hp;
            end
            osc_pkg::ST_A_LU: x_reg  <= sat_w(u_c);
            osc_pkg::ST_A_U2: u2_reg <= r17[20:0];
            osc_pkg::ST_A_LN:
            begin
                rem_reg     <= lim_mag;
                dsh_reg     <= 64'(lim_den) << (osc_pkg::DIV_BITS - 1);
                sign_reg    <= p_reg[67];
                div_lim_reg <= 1'b1;
                cnt_reg     <= osc_pkg::DIV_CNT_W'(osc_pkg::DIV_BITS - 1);
                q_reg       <= '0;
            end
            default: ;
        endcase
    end

endmodule

@@ design/osc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module osc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/osc_checker.sv @@
// Port-level checker for the overdrive chain, bound to the top level.
// Depends on osc_pkg and overdrive_sample_chain_top_defines.svh.
`include "overdrive_sample_chain_top_defines.svh"

module osc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input osc_pkg::out_beat_t out_data
);

    // a waiting result keeps its beat
    `OSC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
    // one sample in flight: input closes right after a beat is taken
    `OSC_ASSERT_NEXT(a_busy_after_in, in_valid && !in_stall, in_stall)
    // no result appears in the cycle right after an input beat
    `OSC_ASSERT_NEXT(a_no_instant_out, in_valid && !in_stall, !$rose(out_valid))
    // a new result coincides with the input reopening
    `OSC_ASSERT_NOW(a_out_frees_in, $rose(out_valid), !in_stall)

endmodule

bind overdrive_sample_chain_top osc_checker u_osc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
